### hw/rtl/connected_component_sizes_macros.svh
// ----------------------------------------------------------------------------
// connected_component_sizes_macros.svh
// Assertion macros for the connected component sizes block.
// ----------------------------------------------------------------------------
`ifndef CONNECTED_COMPONENT_SIZES_MACROS_SVH
`define CONNECTED_COMPONENT_SIZES_MACROS_SVH
`ifndef SYNTHESIS
`define CCS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CCS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) cond |=> prop) else $error(msg);
`else
`define CCS_ASSERT(label, clk, rst, prop, msg)
`define CCS_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

### hw/rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared constants and controller/datapath types.
// ----------------------------------------------------------------------------
package ccs_pkg;

   localparam int MAX_VERTICES_DEFAULT = 64;
   localparam int VERTEX_W             = 6;
   localparam int COUNT_W              = 7;
   localparam int SIZE_W               = 7;

   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic ready;
      logic adj_rd_a;
      logic adj_wr_a;
      logic adj_rd_b;
      logic adj_wr_b;
      logic root_clear;
      logic root_start;
      logic root_next;
      logic pop;
      logic adj_rd_top;
      logic load_fresh;
      logic scan_step;
      logic size_wr;
      logic lbl_rd;
      logic sz_rd;
      logic out_load;
      logic clear;
   } ccs_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_kind;
      logic edge_ok;
      logic root_done;
      logic root_visited;
      logic sp_zero;
      logic fresh_zero;
      logic out_taken;
      logic out_last;
   } ccs_status_type;

endpackage

### hw/rtl/ccs_if.sv
// ----------------------------------------------------------------------------
// ccs_if
// Item channels: edge/end requests in, component size responses out.
// ----------------------------------------------------------------------------
interface ccs_req_if;
   import ccs_pkg::*;

   logic                valid;
   logic                ready;
   logic                kind;
   logic [VERTEX_W-1:0] vertex_a;
   logic [VERTEX_W-1:0] vertex_b;

   modport source (output valid, kind, vertex_a, vertex_b, input ready);
   modport sink   (input valid, kind, vertex_a, vertex_b, output ready);
endinterface

interface ccs_rsp_if;
   import ccs_pkg::*;

   logic                valid;
   logic                ready;
   logic [VERTEX_W-1:0] vertex_index;
   logic [SIZE_W-1:0]   component_size;
   logic                last;

   modport source (output valid, vertex_index, component_size, last, input ready);
   modport sink   (input valid, vertex_index, component_size, last, output ready);
endinterface

### hw/rtl/ccs_ram.sv
// ----------------------------------------------------------------------------
// ccs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ccs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/ccs_ctrl.sv
// ----------------------------------------------------------------------------
// ccs_ctrl
// Sequencer for edge updates, the depth-first walk and result emission.
// ----------------------------------------------------------------------------
module ccs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  ccs_pkg::ccs_status_type status,
   output ccs_pkg::ccs_cmd_type    cmd
);
   import ccs_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_EDGE_RD_A = 4'd1;
   localparam logic [3:0] S_EDGE_WR_A = 4'd2;
   localparam logic [3:0] S_EDGE_RD_B = 4'd3;
   localparam logic [3:0] S_EDGE_WR_B = 4'd4;
   localparam logic [3:0] S_ROOT      = 4'd5;
   localparam logic [3:0] S_POP       = 4'd6;
   localparam logic [3:0] S_ROW       = 4'd7;
   localparam logic [3:0] S_FRESH     = 4'd8;
   localparam logic [3:0] S_SCAN      = 4'd9;
   localparam logic [3:0] S_OUT_LBL   = 4'd10;
   localparam logic [3:0] S_OUT_SZ    = 4'd11;
   localparam logic [3:0] S_OUT_LOAD  = 4'd12;
   localparam logic [3:0] S_OUT_WAIT  = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (status.req_valid) begin
               if (status.req_kind == KIND_END) begin
                  cmd.root_clear = 1'b1;
                  state_in       = S_ROOT;
               end else begin
                  state_in = S_EDGE_RD_A;
               end
            end
         end
         S_EDGE_RD_A: begin
            if (status.edge_ok) begin
               cmd.adj_rd_a = 1'b1;
               state_in     = S_EDGE_WR_A;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EDGE_WR_A: begin
            cmd.adj_wr_a = 1'b1;
            state_in     = S_EDGE_RD_B;
         end
         S_EDGE_RD_B: begin
            cmd.adj_rd_b = 1'b1;
            state_in     = S_EDGE_WR_B;
         end
         S_EDGE_WR_B: begin
            cmd.adj_wr_b = 1'b1;
            state_in     = S_IDLE;
         end
         S_ROOT: begin
            if (status.root_done) begin
               cmd.root_clear = 1'b1;
               state_in       = S_OUT_LBL;
            end else if (status.root_visited) begin
               cmd.root_next = 1'b1;
            end else begin
               cmd.root_start = 1'b1;
               state_in       = S_POP;
            end
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_ROW;
         end
         S_ROW: begin
            cmd.adj_rd_top = 1'b1;
            state_in       = S_FRESH;
         end
         S_FRESH: begin
            cmd.load_fresh = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            if (!status.fresh_zero) begin
               cmd.scan_step = 1'b1;
            end else if (status.sp_zero) begin
               cmd.size_wr   = 1'b1;
               cmd.root_next = 1'b1;
               state_in      = S_ROOT;
            end else begin
               state_in = S_POP;
            end
         end
         S_OUT_LBL: begin
            cmd.lbl_rd = 1'b1;
            state_in   = S_OUT_SZ;
         end
         S_OUT_SZ: begin
            cmd.sz_rd = 1'b1;
            state_in  = S_OUT_LOAD;
         end
         S_OUT_LOAD: begin
            cmd.out_load = 1'b1;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (status.out_taken) begin
               if (status.out_last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  cmd.root_next = 1'b1;
                  state_in      = S_OUT_LBL;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

### hw/rtl/ccs_datapath.sv
// ----------------------------------------------------------------------------
// ccs_datapath
// Adjacency, label, size and stack stores, walk registers, result register.
// ----------------------------------------------------------------------------
module ccs_datapath #(
   parameter int MAX_VERTICES = ccs_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   ccs_req_if.sink                      req,
   ccs_rsp_if.source                    rsp,
   input  logic                         csr_wr_en,
   input  logic [ccs_pkg::COUNT_W-1:0]  csr_wr_data,
   input  ccs_pkg::ccs_cmd_type         cmd,
   output ccs_pkg::ccs_status_type      status
);
   import ccs_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_VERTICES);

   function automatic logic [VW-1:0] first_set(input logic [MAX_VERTICES-1:0] vec);
      logic [VW-1:0] idx;
      idx = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = VW'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [MAX_VERTICES-1:0] bit_of(input logic [VW-1:0] idx);
      logic [MAX_VERTICES-1:0] vec;
      vec      = '0;
      vec[idx] = 1'b1;
      return vec;
   endfunction

   logic [COUNT_W-1:0]      vertex_count_ff;
   logic [VERTEX_W-1:0]     a_ff;
   logic [VERTEX_W-1:0]     b_ff;
   logic [CW-1:0]           root_ff;
   logic [CW-1:0]           sp_ff;
   logic [SIZE_W-1:0]       size_ff;
   logic [MAX_VERTICES-1:0] visited_ff;
   logic [MAX_VERTICES-1:0] fresh_ff;
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic                    rd_valid_ff;
   logic                    out_valid_ff;
   logic [VERTEX_W-1:0]     out_index_ff;
   logic [SIZE_W-1:0]       out_size_ff;
   logic                    out_last_ff;

   logic [COUNT_W-1:0]      n_count;
   logic [CW-1:0]           n_cw;
   logic [MAX_VERTICES-1:0] vmask;
   logic [VW-1:0]           a_idx;
   logic [VW-1:0]           b_idx;
   logic [VW-1:0]           root_idx;
   logic [VW-1:0]           w_idx;
   logic [MAX_VERTICES-1:0] w_bit;
   logic [MAX_VERTICES-1:0] row_data;
   logic                    accept;

   logic                    adj_wr_en;
   logic [VW-1:0]           adj_wr_addr;
   logic [MAX_VERTICES-1:0] adj_wr_data;
   logic                    adj_rd_en;
   logic [VW-1:0]           adj_rd_addr;
   logic [MAX_VERTICES-1:0] adj_rd_data;
   logic                    lbl_wr_en;
   logic [VW-1:0]           lbl_wr_addr;
   logic [VW-1:0]           lbl_rd_data;
   logic [SIZE_W-1:0]       sz_rd_data;
   logic [VW-1:0]           stk_wr_data;
   logic [VW-1:0]           stk_rd_addr;
   logic [VW-1:0]           stk_rd_data;

   assign n_count = (vertex_count_ff == '0) ? COUNT_W'(1) :
                    (vertex_count_ff > MAX_COUNT) ? MAX_COUNT : vertex_count_ff;
   assign n_cw    = CW'(n_count);

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         vmask[i] = (COUNT_W'(i) < n_count);
      end
   end

   assign a_idx    = a_ff[VW-1:0];
   assign b_idx    = b_ff[VW-1:0];
   assign root_idx = root_ff[VW-1:0];
   assign w_idx    = first_set(fresh_ff);
   assign w_bit    = bit_of(w_idx);
   assign row_data = rd_valid_ff ? adj_rd_data : '0;
   assign accept   = req.valid & cmd.ready;

   assign req.ready = cmd.ready;

   assign status.req_valid    = req.valid;
   assign status.req_kind     = req.kind;
   assign status.edge_ok      = (COUNT_W'(a_ff) < n_count) && (COUNT_W'(b_ff) < n_count);
   assign status.root_done    = (root_ff == n_cw);
   assign status.root_visited = visited_ff[root_idx];
   assign status.sp_zero      = (sp_ff == '0);
   assign status.fresh_zero   = (fresh_ff == '0);
   assign status.out_taken    = out_valid_ff & rsp.ready;
   assign status.out_last     = out_last_ff;

   // adjacency port muxing
   assign adj_wr_en   = cmd.adj_wr_a | cmd.adj_wr_b;
   assign adj_wr_addr = cmd.adj_wr_a ? a_idx : b_idx;
   assign adj_wr_data = row_data | bit_of(cmd.adj_wr_a ? b_idx : a_idx);
   assign adj_rd_en   = cmd.adj_rd_a | cmd.adj_rd_b | cmd.adj_rd_top;
   assign adj_rd_addr = cmd.adj_rd_a ? a_idx : (cmd.adj_rd_b ? b_idx : stk_rd_data);

   assign lbl_wr_en   = cmd.root_start | cmd.scan_step;
   assign lbl_wr_addr = cmd.root_start ? root_idx : w_idx;
   assign stk_wr_data = cmd.root_start ? root_idx : w_idx;
   assign stk_rd_addr = VW'(sp_ff - CW'(1));

   ccs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_en   (adj_rd_en),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   ccs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_label_ram (
      .clock   (clock),
      .wr_en   (lbl_wr_en),
      .wr_addr (lbl_wr_addr),
      .wr_data (root_idx),
      .rd_en   (cmd.lbl_rd),
      .rd_addr (root_idx),
      .rd_data (lbl_rd_data)
   );

   ccs_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_VERTICES)) u_size_ram (
      .clock   (clock),
      .wr_en   (cmd.size_wr),
      .wr_addr (root_idx),
      .wr_data (size_ff),
      .rd_en   (cmd.sz_rd),
      .rd_addr (lbl_rd_data),
      .rd_data (sz_rd_data)
   );

   ccs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (lbl_wr_en),
      .wr_addr (sp_ff[VW-1:0]),
      .wr_data (stk_wr_data),
      .rd_en   (cmd.pop),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff <= req.vertex_a;
         b_ff <= req.vertex_b;
      end
      if (cmd.adj_rd_a) begin
         rd_valid_ff <= row_valid_ff[a_idx];
      end else if (cmd.adj_rd_b) begin
         rd_valid_ff <= row_valid_ff[b_idx];
      end else if (cmd.adj_rd_top) begin
         rd_valid_ff <= row_valid_ff[stk_rd_data];
      end
      if (cmd.load_fresh) begin
         fresh_ff <= row_data & vmask & ~visited_ff;
      end else if (cmd.scan_step) begin
         fresh_ff <= fresh_ff & ~w_bit;
      end
      if (cmd.root_start) begin
         size_ff <= SIZE_W'(1);
      end else if (cmd.scan_step) begin
         size_ff <= size_ff + SIZE_W'(1);
      end
      if (cmd.out_load) begin
         out_index_ff <= VERTEX_W'(root_ff);
         out_size_ff  <= sz_rd_data;
         out_last_ff  <= (root_ff == CW'(n_cw - CW'(1)));
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
         root_ff         <= '0;
         sp_ff           <= '0;
         visited_ff      <= '0;
         row_valid_ff    <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            vertex_count_ff <= csr_wr_data;
         end
         if (cmd.root_clear) begin
            root_ff <= '0;
         end else if (cmd.root_next) begin
            root_ff <= root_ff + CW'(1);
         end
         if (cmd.root_start || cmd.scan_step) begin
            sp_ff <= sp_ff + CW'(1);
         end else if (cmd.pop) begin
            sp_ff <= sp_ff - CW'(1);
         end
         if (cmd.clear || cmd.root_clear) begin
            visited_ff <= '0;
         end else if (cmd.root_start) begin
            visited_ff <= visited_ff | bit_of(root_idx);
         end else if (cmd.scan_step) begin
            visited_ff <= visited_ff | w_bit;
         end
         if (cmd.clear) begin
            row_valid_ff <= '0;
         end else if (adj_wr_en) begin
            row_valid_ff <= row_valid_ff | bit_of(adj_wr_addr);
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.vertex_index   = out_index_ff;
   assign rsp.component_size = out_size_ff;
   assign rsp.last           = out_last_ff;
endmodule

### hw/rtl/connected_component_sizes.sv
// ----------------------------------------------------------------------------
// connected_component_sizes
// Connected component sizes of an undirected graph loaded as edge items.
//
// Edge items set both endpoint bits in a 64x64 adjacency RAM; an edge item
// reads and rewrites the row of each endpoint in turn (a read-modify-write of
// two rows), and is dropped when an endpoint is at or above the vertex count.
// An end item runs a depth-first walk with a stack in RAM: each root candidate
// is checked in turn, and each popped vertex goes through pop, row fetch,
// neighbor load, one scan step per newly found vertex and the scan check that
// finds no more neighbors. Then
// one result per vertex follows, in vertex order, each through label read,
// size read, load and a handoff that waits for the consumer. Rows are
// tracked by valid bits, so the adjacency store is empty again right after the
// last result, with no clearing pass. Input is accepted only while no end
// item is in progress.
// ----------------------------------------------------------------------------
`include "connected_component_sizes_macros.svh"

module connected_component_sizes #(
   parameter int MAX_VERTICES = ccs_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   ccs_req_if.sink                     req_chan,
   ccs_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [ccs_pkg::COUNT_W-1:0] csr_wr_data
);
   import ccs_pkg::*;

   ccs_cmd_type    cmd;
   ccs_status_type status;

   ccs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   ccs_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

   `CCS_ASSERT(a_no_accept_while_emitting, clock, reset, (req_chan.valid && req_chan.ready) |-> !rsp_chan.valid, "item accepted while a result is pending")
   `CCS_ASSERT(a_stack_empty_when_idle, clock, reset, req_chan.ready |-> status.sp_zero, "walk stack not empty while idle")
   `CCS_ASSERT_NEXT(a_last_ends_burst, clock, reset, (rsp_chan.valid && rsp_chan.ready && rsp_chan.last), !rsp_chan.valid && req_chan.ready, "results continue after last")
endmodule
